// File: sv/quaternion_gyro_attitude_integrator_unit_assert.svh
// Assertion macros used by the attitude integrator top level.
`ifndef QUATERNION_GYRO_ATTITUDE_INTEGRATOR_UNIT_ASSERT_SVH
`define QUATERNION_GYRO_ATTITUDE_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QGAI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qgai assertion failed");

// Next-cycle implication, checked out of reset.
`define QGAI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qgai assertion failed");

`endif

// File: sv/qgai_pkg.sv
// Package: payload types, states, datapath commands, status, constants and term table of the attitude integrator.
`default_nettype none
package qgai_pkg;

  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic [23:0]        STEP_RST  = 24'd16777;
  localparam int                 SQRT_ITER = 32;
  localparam int                 DIV_ITER  = 31;

  typedef struct packed {
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               norm_zero;
  } out_data_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TMUL, OP_TACC, OP_HRND, OP_LMUL, OP_LACC, OP_HMUL,
    OP_HACC, OP_SHR, OP_SHL, OP_SQM, OP_SQA, OP_SQI, OP_SQRT, OP_DINIT,
    OP_DIV, OP_DFIN, OP_ZERO, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TMUL, ST_TACC, ST_HRND, ST_LMUL, ST_LACC, ST_HMUL, ST_HACC,
    ST_CHK, ST_NORM, ST_ZERO, ST_SQM, ST_SQA, ST_SQI, ST_SQRT, ST_DINIT,
    ST_DIV, ST_DFIN, ST_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] c;
    logic [1:0] j;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic mag_hi;
    logic mag_lo;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [1:0] att_idx;
    logic [1:0] rate_idx;
    logic       neg;
  } term_t;

  // Hamilton product terms of q * (0, g): component c, term j.
  function automatic term_t term_sel(input logic [1:0] c, input logic [1:0] j);
    term_t t;
    case ({c, j})
      4'b0000: t = '{2'd1, 2'd0, 1'b1};
      4'b0001: t = '{2'd2, 2'd1, 1'b1};
      4'b0010: t = '{2'd3, 2'd2, 1'b1};
      4'b0100: t = '{2'd0, 2'd0, 1'b0};
      4'b0101: t = '{2'd2, 2'd2, 1'b0};
      4'b0110: t = '{2'd3, 2'd1, 1'b1};
      4'b1000: t = '{2'd0, 2'd1, 1'b0};
      4'b1001: t = '{2'd1, 2'd2, 1'b1};
      4'b1010: t = '{2'd3, 2'd0, 1'b0};
      4'b1100: t = '{2'd0, 2'd2, 1'b0};
      4'b1101: t = '{2'd1, 2'd1, 1'b0};
      4'b1110: t = '{2'd2, 2'd0, 1'b1};
      default: t = '{2'd0, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: sv/quaternion_gyro_attitude_integrator_unit.sv
// Top level of the gyro attitude integrator: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_data  (rate_x, rate_y, rate_z)
//   out_     output     out_valid/out_ready  out_data (att_w..att_z, norm_zero)
//   cfg_     input      cfg_we               cfg_wdata (step_time)
//
// A sample passes through the twelve products and step scaling on the shared
// 33x33 multiplier, the normalizing shifts, the sum of squares, the bit-serial
// root and the restoring divider; no new sample is accepted before it is done.
// An all-zero update skips the normalizing, sum of squares, root and divide.
// Reset (rst_n low, synchronous) sets the attitude to identity and step time
// to its default. A result held in the output register while out_ready is
// low stalls the next sample only at its final load.
`default_nettype none
module quaternion_gyro_attitude_integrator_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire qgai_pkg::in_data_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qgai_pkg::out_data_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [23:0]          cfg_wdata
);

`include "quaternion_gyro_attitude_integrator_unit_assert.svh"

  qgai_pkg::cmd_t  cmd;
  qgai_pkg::stat_t stat;
  logic            out_ident;
  logic            w_in_range;

  qgai_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qgai_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Result patterns for the checks
  assign out_ident  = (out_data.att_w == qgai_pkg::ONE_Q30) && (out_data.att_x == '0) &&
                      (out_data.att_y == '0) && (out_data.att_z == '0);
  assign w_in_range = (out_data.att_w <= qgai_pkg::ONE_Q30) &&
                      (out_data.att_w >= -qgai_pkg::ONE_Q30);

  // Checks
  `QGAI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `QGAI_ASSERT_IMP(a_zero_is_identity, out_valid && out_data.norm_zero, out_ident)
  `QGAI_ASSERT_IMP(a_w_bounded, out_valid, w_in_range)

endmodule
`default_nettype wire

// File: sv/qgai_ctrl.sv
// Controller: sequences the shared multiplier, root and divide steps per sample.
`default_nettype none
module qgai_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qgai_pkg::stat_t stat,
  output qgai_pkg::cmd_t     cmd
);

  qgai_pkg::state_t state_r, state_nxt;
  logic [1:0] c_r, c_nxt;
  logic [1:0] j_r, j_nxt;
  logic [4:0] it_r, it_nxt;

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qgai_pkg::ST_IDLE;
      c_r     <= '0;
      j_r     <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      j_r     <= j_nxt;
      it_r    <= it_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    j_nxt     = j_r;
    it_nxt    = it_r;
    case (state_r)
      qgai_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = qgai_pkg::ST_TMUL;
          c_nxt     = '0;
          j_nxt     = '0;
        end
      end
      qgai_pkg::ST_TMUL: state_nxt = qgai_pkg::ST_TACC;
      qgai_pkg::ST_TACC: begin
        if (j_r == 2'd2) begin
          state_nxt = qgai_pkg::ST_HRND;
          j_nxt     = '0;
        end else begin
          state_nxt = qgai_pkg::ST_TMUL;
          j_nxt     = j_r + 2'd1;
        end
      end
      qgai_pkg::ST_HRND: state_nxt = qgai_pkg::ST_LMUL;
      qgai_pkg::ST_LMUL: state_nxt = qgai_pkg::ST_LACC;
      qgai_pkg::ST_LACC: state_nxt = qgai_pkg::ST_HMUL;
      qgai_pkg::ST_HMUL: state_nxt = qgai_pkg::ST_HACC;
      qgai_pkg::ST_HACC: begin
        c_nxt = c_r + 2'd1;
        state_nxt = (c_r == 2'd3) ? qgai_pkg::ST_CHK : qgai_pkg::ST_TMUL;
      end
      qgai_pkg::ST_CHK: state_nxt = stat.mag_zero ? qgai_pkg::ST_ZERO : qgai_pkg::ST_NORM;
      qgai_pkg::ST_NORM: begin
        if (!stat.mag_hi && !stat.mag_lo) begin
          state_nxt = qgai_pkg::ST_SQM;
          j_nxt     = '0;
        end
      end
      qgai_pkg::ST_ZERO: state_nxt = qgai_pkg::ST_OUT;
      qgai_pkg::ST_SQM:  state_nxt = qgai_pkg::ST_SQA;
      qgai_pkg::ST_SQA: begin
        j_nxt = j_r + 2'd1;
        state_nxt = (j_r == 2'd3) ? qgai_pkg::ST_SQI : qgai_pkg::ST_SQM;
      end
      qgai_pkg::ST_SQI: begin
        state_nxt = qgai_pkg::ST_SQRT;
        it_nxt    = '0;
      end
      qgai_pkg::ST_SQRT: begin
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(qgai_pkg::SQRT_ITER - 1)) begin
          state_nxt = qgai_pkg::ST_DINIT;
          c_nxt     = '0;
        end
      end
      qgai_pkg::ST_DINIT: begin
        state_nxt = qgai_pkg::ST_DIV;
        it_nxt    = '0;
      end
      qgai_pkg::ST_DIV: begin
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(qgai_pkg::DIV_ITER - 1)) state_nxt = qgai_pkg::ST_DFIN;
      end
      qgai_pkg::ST_DFIN: begin
        c_nxt = c_r + 2'd1;
        state_nxt = (c_r == 2'd3) ? qgai_pkg::ST_OUT : qgai_pkg::ST_DINIT;
      end
      qgai_pkg::ST_OUT: begin
        if (stat.out_free) state_nxt = qgai_pkg::ST_IDLE;
      end
      default: state_nxt = qgai_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.c    = c_r;
    cmd.j    = j_r;
    cmd.op   = qgai_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      qgai_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = qgai_pkg::OP_LOAD;
      end
      qgai_pkg::ST_TMUL:  cmd.op = qgai_pkg::OP_TMUL;
      qgai_pkg::ST_TACC:  cmd.op = qgai_pkg::OP_TACC;
      qgai_pkg::ST_HRND:  cmd.op = qgai_pkg::OP_HRND;
      qgai_pkg::ST_LMUL:  cmd.op = qgai_pkg::OP_LMUL;
      qgai_pkg::ST_LACC:  cmd.op = qgai_pkg::OP_LACC;
      qgai_pkg::ST_HMUL:  cmd.op = qgai_pkg::OP_HMUL;
      qgai_pkg::ST_HACC:  cmd.op = qgai_pkg::OP_HACC;
      qgai_pkg::ST_CHK:   cmd.op = qgai_pkg::OP_NONE;
      qgai_pkg::ST_NORM: begin
        if (stat.mag_hi)      cmd.op = qgai_pkg::OP_SHR;
        else if (stat.mag_lo) cmd.op = qgai_pkg::OP_SHL;
      end
      qgai_pkg::ST_ZERO:  cmd.op = qgai_pkg::OP_ZERO;
      qgai_pkg::ST_SQM:   cmd.op = qgai_pkg::OP_SQM;
      qgai_pkg::ST_SQA:   cmd.op = qgai_pkg::OP_SQA;
      qgai_pkg::ST_SQI:   cmd.op = qgai_pkg::OP_SQI;
      qgai_pkg::ST_SQRT:  cmd.op = qgai_pkg::OP_SQRT;
      qgai_pkg::ST_DINIT: cmd.op = qgai_pkg::OP_DINIT;
      qgai_pkg::ST_DIV:   cmd.op = qgai_pkg::OP_DIV;
      qgai_pkg::ST_DFIN:  cmd.op = qgai_pkg::OP_DFIN;
      qgai_pkg::ST_OUT: begin
        if (stat.out_free) cmd.op = qgai_pkg::OP_OUT;
      end
      default: cmd.op = qgai_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/qgai_dpath.sv
// Datapath: attitude store, shared multiplier, integer root and restoring divider.
`default_nettype none
module qgai_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qgai_pkg::cmd_t      cmd,
  output qgai_pkg::stat_t          stat,
  input  wire qgai_pkg::in_data_t  in_data,
  input  wire logic                cfg_we,
  input  wire logic [23:0]         cfg_wdata,
  output qgai_pkg::out_data_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  logic signed [31:0] att_r [4];
  logic signed [23:0] rate_r [3];
  logic [23:0]        step_r;
  logic signed [65:0] prod_r;
  logic signed [57:0] acc_r;
  logic signed [40:0] h_r;
  logic [24:0]        t_r;
  logic [41:0]        m_r [4];
  logic [3:0]         neg_r;
  logic [63:0]        sum_r, src_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;
  logic [31:0]        drem_r;
  logic [30:0]        dlo_r, q_r;
  logic               zf_r;
  qgai_pkg::out_data_t out_r;
  logic               out_valid_r;

  qgai_pkg::term_t    term;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_c;
  logic signed [57:0] p_term, acc_base, acc_sum, acc_rnd;
  logic [48:0]        lo_rnd;
  logic signed [42:0] a_sum, a_abs;
  logic [41:0]        m_or;
  logic [35:0]        sq_remx, sq_trial, sq_diff;
  logic               sq_ge;
  logic [61:0]        num;
  logic [32:0]        dv_remx, dv_diff;
  logic               dv_ge;
  logic [30:0]        q_mag;
  logic signed [31:0] q_val;

  assign term = qgai_pkg::term_sel(cmd.c, cmd.j);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      qgai_pkg::OP_TMUL: begin
        mul_a = {att_r[term.att_idx][31], att_r[term.att_idx]};
        mul_b = {{9{rate_r[term.rate_idx][23]}}, rate_r[term.rate_idx]};
      end
      qgai_pkg::OP_LMUL: begin
        mul_a = {9'b0, h_r[23:0]};
        mul_b = {9'b0, step_r};
      end
      qgai_pkg::OP_HMUL: begin
        mul_a = {{16{h_r[40]}}, h_r[40:24]};
        mul_b = {9'b0, step_r};
      end
      qgai_pkg::OP_SQM: begin
        mul_a = {2'b0, m_r[cmd.j][30:0]};
        mul_b = {2'b0, m_r[cmd.j][30:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Term accumulation and rounding
  assign p_term   = prod_r[57:0];
  assign acc_base = (cmd.j == 2'd0) ? 58'sd0 : acc_r;
  assign acc_sum  = term.neg ? (acc_base - p_term) : (acc_base + p_term);
  assign acc_rnd  = acc_r + 58'sd65536;
  assign lo_rnd   = prod_r[48:0] + 49'd8388608;

  // Updated component and its magnitude
  assign a_sum = {{11{att_r[cmd.c][31]}}, att_r[cmd.c]} + prod_r[42:0] + {18'b0, t_r};
  assign a_abs = a_sum[42] ? -a_sum : a_sum;

  assign m_or = m_r[0] | m_r[1] | m_r[2] | m_r[3];

  // One root digit per cycle
  assign sq_remx  = {rem_r, src_r[63:62]};
  assign sq_trial = {2'b0, root_r, 2'b01};
  assign sq_diff  = sq_remx - sq_trial;
  assign sq_ge    = (sq_remx >= sq_trial);

  // One quotient bit per cycle
  assign num     = {1'b0, m_r[cmd.c][30:0], 30'b0} + {31'b0, root_r[31:1]};
  assign dv_remx = {drem_r, dlo_r[30]};
  assign dv_diff = dv_remx - {1'b0, root_r};
  assign dv_ge   = (dv_remx >= {1'b0, root_r});
  assign q_mag   = (q_r > 31'(qgai_pkg::ONE_Q30)) ? 31'(qgai_pkg::ONE_Q30) : q_r;
  assign q_val   = neg_r[cmd.c] ? -{1'b0, q_mag} : {1'b0, q_mag};

  assign stat.mag_zero = (m_or == '0);
  assign stat.mag_hi   = |m_or[41:31];
  assign stat.mag_lo   = !m_or[30] && !(|m_or[41:31]);
  assign stat.out_free = !out_valid_r || out_ready;

  // Hold step time and attitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= qgai_pkg::STEP_RST;
      att_r[0] <= qgai_pkg::ONE_Q30;
      att_r[1] <= '0;
      att_r[2] <= '0;
      att_r[3] <= '0;
    end else begin
      if (cfg_we) step_r <= cfg_wdata;
      if (cmd.op == qgai_pkg::OP_DFIN) att_r[cmd.c] <= q_val;
      if (cmd.op == qgai_pkg::OP_ZERO) begin
        att_r[0] <= qgai_pkg::ONE_Q30;
        att_r[1] <= '0;
        att_r[2] <= '0;
        att_r[3] <= '0;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    case (cmd.op)
      qgai_pkg::OP_LOAD: begin
        rate_r[0] <= in_data.rate_x;
        rate_r[1] <= in_data.rate_y;
        rate_r[2] <= in_data.rate_z;
        zf_r      <= 1'b0;
      end
      qgai_pkg::OP_TACC: acc_r <= acc_sum;
      qgai_pkg::OP_HRND: h_r <= acc_rnd[57:17];
      qgai_pkg::OP_LACC: t_r <= lo_rnd[48:24];
      qgai_pkg::OP_HACC: begin
        m_r[cmd.c]   <= a_abs[41:0];
        neg_r[cmd.c] <= a_sum[42];
      end
      qgai_pkg::OP_SHR: for (int i = 0; i < 4; i++) m_r[i] <= m_r[i] >> 1;
      qgai_pkg::OP_SHL: for (int i = 0; i < 4; i++) m_r[i] <= m_r[i] << 1;
      qgai_pkg::OP_SQA: sum_r <= ((cmd.j == 2'd0) ? 64'd0 : sum_r) + prod_r[63:0];
      qgai_pkg::OP_SQI: begin
        src_r  <= sum_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      qgai_pkg::OP_SQRT: begin
        src_r  <= {src_r[61:0], 2'b00};
        rem_r  <= sq_ge ? sq_diff[33:0] : sq_remx[33:0];
        root_r <= {root_r[30:0], sq_ge};
      end
      qgai_pkg::OP_DINIT: begin
        drem_r <= {1'b0, num[61:31]};
        dlo_r  <= num[30:0];
        q_r    <= '0;
      end
      qgai_pkg::OP_DIV: begin
        drem_r <= dv_ge ? dv_diff[31:0] : dv_remx[31:0];
        dlo_r  <= {dlo_r[29:0], 1'b0};
        q_r    <= {q_r[29:0], dv_ge};
      end
      qgai_pkg::OP_ZERO: zf_r <= 1'b1;
      default: ;
    endcase
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == qgai_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == qgai_pkg::OP_OUT) begin
      out_r.att_w     <= att_r[0];
      out_r.att_x     <= att_r[1];
      out_r.att_y     <= att_r[2];
      out_r.att_z     <= att_r[3];
      out_r.norm_zero <= zf_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
